@@ src/apfi_pkg.sv @@
// shared types, constants and stage map for the animation progress / frame index core
// no dependencies; used by the interfaces, the stage module and the top level
package apfi_pkg;

    localparam int TIME_BITS       = 40;
    localparam int FRAME_BITS      = 16;
    localparam int RATIO_FRAC_BITS = 16;
    localparam int CFG_BITS        = 32;
    localparam int PROG_BITS       = RATIO_FRAC_BITS + 1;
    localparam int PERIOD_BITS     = CFG_BITS + 1;
    localparam int MREM_BITS       = PERIOD_BITS + 1;
    localparam int PROD_BITS       = FRAME_BITS + PROG_BITS;

    // stage map: input, one remainder step per time bit, adjust,
    // one quotient bit per stage, multiply, output
    localparam int ST_IN        = 0;
    localparam int ST_MOD_FIRST = 1;
    localparam int ST_MOD_LAST  = ST_MOD_FIRST + TIME_BITS - 1;
    localparam int ST_ADJ       = ST_MOD_LAST + 1;
    localparam int ST_DIV_FIRST = ST_ADJ + 1;
    localparam int ST_DIV_LAST  = ST_DIV_FIRST + PROG_BITS - 1;
    localparam int ST_MUL       = ST_DIV_LAST + 1;
    localparam int ST_OUT       = ST_MUL + 1;
    localparam int N_STAGES     = ST_OUT + 1;
    localparam int STAGE_BITS   = $clog2(N_STAGES);

    localparam logic [PROG_BITS-1:0] RATIO_ONE  = PROG_BITS'(1) << RATIO_FRAC_BITS;
    localparam logic [PROG_BITS-1:0] RATIO_ZERO = '0;

    // loop modes
    localparam logic [1:0] MODE_ONCE   = 2'd0;
    localparam logic [1:0] MODE_REPEAT = 2'd1;
    localparam logic [1:0] MODE_FLIP   = 2'd2;

    // register indexes
    localparam logic [1:0] REG_START_DELAY  = 2'd0;
    localparam logic [1:0] REG_RUN_LENGTH   = 2'd1;
    localparam logic [1:0] REG_PLAY_REVERSE = 2'd2;
    localparam logic [1:0] REG_LOOP_MODE    = 2'd3;

    typedef struct packed {
        logic [CFG_BITS-1:0] start_delay;
        logic [CFG_BITS-1:0] run_length;
        logic                play_reverse;
        logic [1:0]          loop_mode;
    } cfg_t;

    typedef struct packed {
        logic [TIME_BITS-1:0]   t;
        logic [TIME_BITS-1:0]   x;
        logic [FRAME_BITS-1:0]  frames;
        logic [MREM_BITS-1:0]   mrem;
        logic                   qlsb;
        logic                   spec;
        logic [PROG_BITS-1:0]   sprog;
        logic [PERIOD_BITS-1:0] drem;
        logic [PROG_BITS-1:0]   quot;
        logic [PROG_BITS-1:0]   prog;
        logic [PROD_BITS-1:0]   prod;
        logic [FRAME_BITS-1:0]  idx;
    } stage_t;

endpackage

@@ src/apfi_if.sv @@
// valid/ready channel interfaces for query input and result output
// depends on apfi_pkg for field widths
interface apfi_in_if import apfi_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [TIME_BITS-1:0]  elapsed_time;
    logic [FRAME_BITS-1:0] frame_total;
    modport source (output valid, elapsed_time, frame_total, input ready);
    modport sink (input valid, elapsed_time, frame_total, output ready);
endinterface

interface apfi_out_if import apfi_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [PROG_BITS-1:0]  progress;
    logic [FRAME_BITS-1:0] frame_index;
    modport source (output valid, progress, frame_index, input ready);
    modport sink (input valid, progress, frame_index, output ready);
endinterface

@@ src/animation_progress_frame_index_core.sv @@
// Animation progress / frame index core: maps elapsed time to a Q1.16 ratio and a frame
// index. A query passes one stage per bit of the period remainder (40), one per quotient
// bit of the ratio (17), and input, adjust, multiply and output stages. A new query is
// accepted every cycle unless back-pressure fills the first stage; a stalled output holds
// only the stages that are full. The user must write configuration only while no query is
// in flight; the block does not enforce this. Depends on apfi_pkg, apfi_if and apfi_stage
module animation_progress_frame_index_core import apfi_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data,
    apfi_in_if.sink             in_ch,
    apfi_out_if.source          out_ch
);

    cfg_t   cfg_reg;
    stage_t in_stage;
    stage_t st [N_STAGES];
    stage_t prv [N_STAGES];
    logic   v [N_STAGES];
    logic   pv [N_STAGES];
    logic   rdy [N_STAGES+1];

    // configuration write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_START_DELAY:  cfg_reg.start_delay  <= cfg_data;
                REG_RUN_LENGTH:   cfg_reg.run_length   <= cfg_data;
                REG_PLAY_REVERSE: cfg_reg.play_reverse <= cfg_data[0];
                REG_LOOP_MODE:    cfg_reg.loop_mode    <= cfg_data[1:0];
                default:          cfg_reg.loop_mode    <= cfg_reg.loop_mode;
            endcase
        end
    end

    // input transfer packed as stage zero payload
    always_comb
    begin
        in_stage        = '0;
        in_stage.t      = in_ch.elapsed_time;
        in_stage.x      = in_ch.elapsed_time - TIME_BITS'(1);
        in_stage.frames = in_ch.frame_total;
    end

    // stage chain with per-stage ready so bubbles collapse under stall
    assign rdy[N_STAGES] = out_ch.ready;
    assign in_ch.ready   = rdy[0];

    genvar i;
    generate
        for (i = 0; i < N_STAGES; i++)
        begin : g_stage
            assign rdy[i] = !v[i] || rdy[i+1];
            if (i == 0)
            begin : g_first
                assign prv[i] = in_stage;
                assign pv[i]  = in_ch.valid;
            end
            else
            begin : g_rest
                assign prv[i] = st[i-1];
                assign pv[i]  = v[i-1];
            end
            apfi_stage u_stage (
                .clk        (clk),
                .rst_n      (rst_n),
                .stage_num  (STAGE_BITS'(i)),
                .cfg        (cfg_reg),
                .prev       (prv[i]),
                .prev_valid (pv[i]),
                .load       (rdy[i]),
                .data       (st[i]),
                .valid      (v[i])
            );
        end
    endgenerate

    // result transfer
    assign out_ch.valid       = v[N_STAGES-1];
    assign out_ch.progress    = st[N_STAGES-1].prog;
    assign out_ch.frame_index = st[N_STAGES-1].idx;

    // checks
    a_prog_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.progress <= RATIO_ONE)
        else $error("progress above one");

    a_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.progress == RATIO_ZERO) |-> out_ch.frame_index == '0)
        else $error("nonzero frame index at zero progress");

    a_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.ready && !in_ch.valid) |=> !v[0])
        else $error("first stage filled without input transfer");

endmodule

@@ src/apfi_stage.sv @@
// one pipeline stage: register with valid, work picked by the stage number
// depends on apfi_pkg
module apfi_stage import apfi_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [STAGE_BITS-1:0] stage_num,
    input  cfg_t                  cfg,
    input  stage_t                prev,
    input  logic                  prev_valid,
    input  logic                  load,
    output stage_t                data,
    output logic                  valid
);

    stage_t                 data_reg, data_next;
    logic                   valid_reg;
    logic [MREM_BITS-1:0]   msh;
    logic                   mq;
    logic [PERIOD_BITS-1:0] period;
    logic                   past, wrap, rev;
    logic [PERIOD_BITS-1:0] r1;
    logic [TIME_BITS-1:0]   t2, u;
    logic [CFG_BITS-1:0]    num;
    logic [PERIOD_BITS-1:0] dsh;
    logic                   dq;
    logic [PROG_BITS-1:0]   p;
    logic [FRAME_BITS:0]    scaled;

    // stage work
    always_comb
    begin
        data_next = prev;
        period = {1'b0, cfg.start_delay} + {1'b0, cfg.run_length};
        msh    = {prev.mrem[PERIOD_BITS-1:0], prev.x[TIME_BITS-1]};
        mq     = msh >= {1'b0, period};
        past   = prev.t > TIME_BITS'(period);
        wrap   = past && (cfg.loop_mode == MODE_REPEAT || cfg.loop_mode == MODE_FLIP);
        rev    = cfg.play_reverse ^ (wrap && cfg.loop_mode == MODE_FLIP && prev.qlsb);
        r1     = prev.mrem[PERIOD_BITS-1:0] + PERIOD_BITS'(1);
        t2     = wrap ? TIME_BITS'(r1) : prev.t;
        u      = t2 - TIME_BITS'(cfg.start_delay);
        num    = rev ? (cfg.run_length - u[CFG_BITS-1:0]) : u[CFG_BITS-1:0];
        dsh    = (stage_num == STAGE_BITS'(ST_DIV_FIRST)) ? prev.drem
                                                          : {prev.drem[CFG_BITS-1:0], 1'b0};
        dq     = dsh >= {1'b0, cfg.run_length};
        p      = prev.spec ? prev.sprog : prev.quot;
        scaled = prev.prod[PROD_BITS-1:RATIO_FRAC_BITS];

        if (stage_num >= STAGE_BITS'(ST_MOD_FIRST) && stage_num <= STAGE_BITS'(ST_MOD_LAST))
        begin
            // restoring remainder step of (t - 1) by the period
            data_next.x    = prev.x << 1;
            data_next.mrem = mq ? (msh - {1'b0, period}) : msh;
            data_next.qlsb = mq;
        end
        else if (stage_num == STAGE_BITS'(ST_ADJ))
        begin
            // wrap, direction and the held-value cases
            data_next.drem = {1'b0, num};
            data_next.quot = '0;
            data_next.spec = 1'b1;
            if (cfg.run_length == '0 || (past && !wrap))
                data_next.sprog = cfg.play_reverse ? RATIO_ZERO : RATIO_ONE;
            else if (t2 < TIME_BITS'(cfg.start_delay))
                data_next.sprog = rev ? RATIO_ONE : RATIO_ZERO;
            else
            begin
                data_next.spec  = 1'b0;
                data_next.sprog = RATIO_ZERO;
            end
        end
        else if (stage_num >= STAGE_BITS'(ST_DIV_FIRST) && stage_num <= STAGE_BITS'(ST_DIV_LAST))
        begin
            // one quotient bit of num * 2^F / run_length
            data_next.drem = dq ? (dsh - {1'b0, cfg.run_length}) : dsh;
            data_next.quot = {prev.quot[PROG_BITS-2:0], dq};
        end
        else if (stage_num == STAGE_BITS'(ST_MUL))
        begin
            data_next.prog = p;
            data_next.prod = PROD_BITS'(prev.frames * p);
        end
        else if (stage_num == STAGE_BITS'(ST_OUT))
        begin
            data_next.idx = (scaled == '0) ? '0 : FRAME_BITS'(scaled - 1'b1);
        end
    end

    // stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= prev_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load && prev_valid)
            data_reg <= data_next;
    end

    assign data  = data_reg;
    assign valid = valid_reg;

endmodule

@@ bench/tb_chan_if.sv @@
`timescale 1ns / 1ps
// no new interfaces needed: the bench instantiates apfi_in_if and apfi_out_if from the RTL
// this file holds the shared bench-side constants; depends on apfi_pkg
package tb_apfi_pkg;
    import apfi_pkg::*;
    localparam int LATENCY = 61;
endpackage

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// self-checking bench for animation_progress_frame_index_core: directed and random
// time/frame queries under several register settings; depends on apfi_pkg, apfi_if, tb_apfi_pkg
module tb_top;
    import apfi_pkg::*;
    import tb_apfi_pkg::*;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = REG_START_DELAY;
    logic [CFG_BITS-1:0] cfg_data = '0;
    int errors = 0;

    apfi_in_if in_ch ();
    apfi_out_if out_ch ();

    typedef struct packed {
        logic [PROG_BITS-1:0]  progress;
        logic [FRAME_BITS-1:0] frame_index;
    } frame_result_t;

    frame_result_t pending_frames[$];

    // shadow registers
    logic [CFG_BITS-1:0] delay_sh = '0;
    logic [CFG_BITS-1:0] length_sh = '0;
    logic                reverse_sh = 1'b0;
    logic [1:0]          mode_sh = MODE_ONCE;

    animation_progress_frame_index_core DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.elapsed_time = '0;
        in_ch.frame_total = '0;
        out_ch.ready = 1'b0;
    end

    // ratio for one elapsed time under the shadow registers
    function automatic logic [PROG_BITS-1:0] ratio_at(logic [TIME_BITS-1:0] t_in);
        logic [63:0] t, period, wraps, u, len;
        logic rev;
        t = t_in;
        len = length_sh;
        rev = reverse_sh;
        if (len == 0)
            return rev ? RATIO_ZERO : RATIO_ONE;
        period = 64'(delay_sh) + len;
        if (t > period)
        begin
            if (mode_sh == MODE_REPEAT || mode_sh == MODE_FLIP)
            begin
                wraps = (t - 1) / period;
                t = t - wraps * period;
                if (mode_sh == MODE_FLIP && wraps[0])
                    rev = !rev;
            end
            else
                return rev ? RATIO_ZERO : RATIO_ONE;
        end
        if (t < 64'(delay_sh))
            return rev ? RATIO_ONE : RATIO_ZERO;
        u = t - delay_sh;
        if (rev)
            return PROG_BITS'(((len - u) << RATIO_FRAC_BITS) / len);
        return PROG_BITS'((u << RATIO_FRAC_BITS) / len);
    endfunction

    function automatic frame_result_t frame_for(logic [TIME_BITS-1:0] t,
                                                logic [FRAME_BITS-1:0] n);
        frame_result_t r;
        logic [63:0] scaled;
        r.progress = ratio_at(t);
        scaled = (64'(n) * 64'(r.progress)) >> RATIO_FRAC_BITS;
        r.frame_index = (scaled == 0) ? '0 : FRAME_BITS'(scaled - 1);
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_BITS-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_START_DELAY:  delay_sh = val;
            REG_RUN_LENGTH:   length_sh = val;
            REG_PLAY_REVERSE: reverse_sh = val[0];
            default:          mode_sh = val[1:0];
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // stop sending and wait until every result is back
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic set_all(logic [31:0] d, logic [31:0] l, logic r, logic [1:0] m);
        drain();
        write_reg(REG_START_DELAY, d);
        write_reg(REG_RUN_LENGTH, l);
        write_reg(REG_PLAY_REVERSE, {31'b0, r});
        write_reg(REG_LOOP_MODE, {30'b0, m});
    endtask

    int burst_left = 0;

    // one query transfer, with bursty sender gaps
    task automatic send_query(logic [TIME_BITS-1:0] t, logic [FRAME_BITS-1:0] n);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.elapsed_time <= t;
        in_ch.frame_total <= n;
        do
            @(posedge clk);
        while (!in_ch.ready);
        pending_frames.push_back(frame_for(t, n));
    endtask

    // receiver stall pattern: runs of ready, most of them followed by a run of stall
    initial
    begin
        int run;
        @(posedge rst_n);
        forever
        begin
            run = $urandom_range(1, 30);
            out_ch.ready <= 1'b1;
            repeat (run) @(posedge clk);
            if ($urandom_range(0, 3) != 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        frame_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_frames.size() == 0)
                report("unexpected result", out_ch.progress, 0);
            else
            begin
                want = pending_frames.pop_front();
                if (out_ch.progress !== want.progress)
                    report("progress", out_ch.progress, want.progress);
                if (out_ch.frame_index !== want.frame_index)
                    report("frame_index", out_ch.frame_index, want.frame_index);
            end
        end
    end

    function automatic logic [TIME_BITS-1:0] rand_time();
        logic [63:0] p;
        p = 64'(delay_sh) + length_sh;
        case ($urandom_range(0, 4))
            0: return TIME_BITS'({$urandom, $urandom});
            1: return TIME_BITS'(p + $urandom_range(0, 2) - 1);
            2: return TIME_BITS'(p * $urandom_range(0, 5) + $urandom_range(0, 3));
            default: return TIME_BITS'(($urandom % (p * 4 + 3)));
        endcase
    endfunction

    task automatic test_reset_values();
        send_query('0, '0);
        send_query('1, '1);
        send_query(40'd12345, 16'd100);
    endtask

    task automatic test_special_cases();
        set_all(32'd10, 32'd100, 1'b0, MODE_ONCE);
        send_query(40'd5, 16'd8);        // within delay
        send_query(40'd10, 16'd8);       // start of motion, index underflow
        send_query(40'd60, 16'hFFFF);
        send_query(40'd110, 16'd8);      // exactly at period end
        send_query(40'd111, 16'd8);      // past end, once
        send_query('1, 16'hFFFF);
        set_all(32'd10, 32'd100, 1'b1, MODE_REPEAT);
        send_query(40'd5, 16'd8);
        send_query(40'd110, 16'd8);
        send_query(40'd111, 16'd8);
        send_query(40'd225, 16'd8);
        set_all(32'd3, 32'd7, 1'b0, MODE_FLIP);
        send_query(40'd11, 16'd4);       // past the first period, flipped
        send_query(40'd20, 16'd4);
        send_query(40'd21, 16'd4);
        set_all(32'd3, 32'd7, 1'b0, 2'd3);
        send_query(40'd15, 16'd4);       // unused mode acts as once
        set_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, MODE_FLIP);
        send_query('1, 16'hFFFF);
        send_query(40'h1_FFFF_FFFF, 16'd1);
        send_query(40'h2_0000_0000, 16'hFFFF);
        set_all(32'd0, 32'd0, 1'b1, MODE_REPEAT);  // zero duration
        send_query(40'd7, 16'd9);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 60 == 0)
            begin
                set_all($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 50),
                        $urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, 200),
                        1'($urandom), 2'($urandom));
            end
            if (i == count / 2)
                drain();
            send_query(rand_time(), 16'($urandom));
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_special_cases();
        test_random(530);
        drain();
        if (errors == 0 && pending_frames.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        #400000;
        $display("tb_top NOT OK");
        $finish;
    end
endmodule

@@ filelist.f @@
src/apfi_pkg.sv
src/apfi_if.sv
src/apfi_stage.sv
src/animation_progress_frame_index_core.sv
bench/tb_chan_if.sv
bench/tb_top.sv
